// ----- src/arss_pkg.sv -----
// Package for the actuator run unit with stall and limit-switch stop.
// Holds request/result/config types and the codes shared by all files.
// No dependencies.
package arss_pkg;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // Job directions
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Job status codes as shown on the result
    localparam logic [1:0] STATUS_FREE = 2'd0;
    localparam logic [1:0] STATUS_RUN  = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;

    // Stop causes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_TARGET = 2'd1;
    localparam logic [1:0] CAUSE_STALL  = 2'd2;
    localparam logic [1:0] CAUSE_LIMIT  = 2'd3;

    // Register indexes
    localparam logic REG_STALL_TIMEOUT = 1'b0;
    localparam logic REG_SWITCH_STOP   = 1'b1;

    // Limits and reset values
    localparam logic [6:0]  SPEED_MAX           = 7'd100;
    localparam logic [19:0] TICKS_PER_MS        = 20'd10;
    localparam logic [15:0] STALL_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] COUNT_MAX           = 16'hFFFF;
    localparam logic [19:0] STALL_MAX           = 20'hFFFFF;
    localparam logic [6:0]  RUN_SPEED_RESET     = 7'd100;
    localparam logic [15:0] RUN_TARGET_RESET    = 16'd100;

    typedef struct packed {
        logic [15:0] stall_timeout_ms;
        logic        switch_stop_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  job_dir;
        logic [6:0]  job_speed;
        logic        job_count_mode;
        logic [15:0] job_target;
        logic [3:0]  hall_pulses;
        logic        limit_switch;
    } t_req;

    typedef struct packed {
        logic [6:0]  drive_speed;
        logic        power_on;
        logic        direction_down;
        logic        brake_on;
        logic [1:0]  job_state;
        logic [1:0]  stop_cause;
        logic [15:0] pulse_total;
    } t_result;

endpackage

// ----- src/arss_ctrl.sv -----
// Job controller: holds the job and drive state and computes one result per request.
// Depends on arss_pkg.
module arss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  arss_pkg::t_req    i_req,
    input  arss_pkg::t_cfg    i_cfg,
    output arss_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        JOB_FREE = 3'b001,
        JOB_RUN  = 3'b010,
        JOB_DONE = 3'b100
    } t_job;

    logic [1:0]  r_run_dir,    n_run_dir;
    logic [6:0]  r_run_speed,  n_run_speed;
    logic        r_run_count,  n_run_count;
    logic [15:0] r_run_target, n_run_target;
    logic [15:0] r_hall_total, n_hall_total;
    logic [15:0] r_seen_total, n_seen_total;
    logic [19:0] r_stall,      n_stall;
    t_job        r_job,        n_job;
    logic [6:0]  r_drive,      n_drive;
    logic        r_power,      n_power;
    logic        r_brake,      n_brake;

    logic [1:0]  w_cause;
    logic [16:0] w_sum;
    logic [15:0] w_hall;
    logic [19:0] w_stall_inc;
    logic [19:0] w_stall_limit;
    logic        w_stall;
    logic [1:0]  w_job_code;

    // Stall limit in ticks and saturated hall sum
    assign w_stall_limit = 20'(i_cfg.stall_timeout_ms) * arss_pkg::TICKS_PER_MS;
    assign w_sum         = {1'b0, r_hall_total} + {13'b0, i_req.hall_pulses};
    assign w_hall        = w_sum[16] ? arss_pkg::COUNT_MAX : w_sum[15:0];
    assign w_stall_inc   = (r_stall != arss_pkg::STALL_MAX) ? r_stall + 20'd1 : r_stall;

    // Next-state logic for one request
    always_comb begin
        n_run_dir    = r_run_dir;
        n_run_speed  = r_run_speed;
        n_run_count  = r_run_count;
        n_run_target = r_run_target;
        n_hall_total = r_hall_total;
        n_seen_total = r_seen_total;
        n_stall      = r_stall;
        n_job        = r_job;
        n_drive      = r_drive;
        n_power      = r_power;
        n_brake      = r_brake;
        w_cause      = arss_pkg::CAUSE_NONE;
        w_stall      = 1'b0;
        unique case (i_req.req_type)
            arss_pkg::REQ_TICK: begin
                if (r_run_dir == arss_pkg::DIR_STOP) begin
                    n_brake      = i_cfg.switch_stop_enable;
                    n_drive      = '0;
                    n_power      = 1'b0;
                    n_hall_total = '0;
                    n_seen_total = '0;
                    n_stall      = '0;
                end else begin
                    n_brake      = 1'b0;
                    n_power      = 1'b1;
                    n_hall_total = w_hall;
                    if (w_hall != r_seen_total) begin
                        n_seen_total = w_hall;
                        n_stall      = '0;
                    end else begin
                        n_stall = w_stall_inc;
                        w_stall = (w_stall_inc >= w_stall_limit);
                    end
                    // stall wins over target, target over limit switch
                    priority if (w_stall) begin
                        w_cause = arss_pkg::CAUSE_STALL;
                    end else if (r_run_count && (w_hall >= r_run_target)) begin
                        w_cause = arss_pkg::CAUSE_TARGET;
                    end else if (i_cfg.switch_stop_enable && i_req.limit_switch &&
                                 (r_run_dir == arss_pkg::DIR_DOWN)) begin
                        w_cause = arss_pkg::CAUSE_LIMIT;
                    end else begin
                        w_cause = arss_pkg::CAUSE_NONE;
                    end
                    if (w_cause != arss_pkg::CAUSE_NONE) begin
                        n_run_dir    = arss_pkg::DIR_STOP;
                        n_hall_total = '0;
                        n_seen_total = '0;
                        n_stall      = '0;
                        n_job        = JOB_DONE;
                        n_drive      = '0;
                        n_power      = 1'b0;
                        n_brake      = (w_cause == arss_pkg::CAUSE_LIMIT);
                    end else if (r_run_speed <= arss_pkg::SPEED_MAX) begin
                        n_drive = r_run_speed;
                    end
                end
            end
            arss_pkg::REQ_START: begin
                if (r_job == JOB_FREE) begin
                    n_run_dir    = i_req.job_dir;
                    n_run_speed  = i_req.job_speed;
                    n_run_count  = i_req.job_count_mode;
                    n_run_target = i_req.job_target;
                    n_hall_total = '0;
                    n_seen_total = '0;
                    n_stall      = '0;
                    n_job        = JOB_RUN;
                end
            end
            arss_pkg::REQ_CLEAR: begin
                n_job = JOB_FREE;
            end
            arss_pkg::REQ_NOP: begin
                n_job = r_job;
            end
            default: begin
                n_job = r_job;
            end
        endcase
    end

    // Status code for the result
    always_comb begin
        unique case (n_job)
            JOB_FREE: w_job_code = arss_pkg::STATUS_FREE;
            JOB_RUN:  w_job_code = arss_pkg::STATUS_RUN;
            JOB_DONE: w_job_code = arss_pkg::STATUS_DONE;
            default:  w_job_code = arss_pkg::STATUS_FREE;
        endcase
    end

    assign o_res.drive_speed    = n_drive;
    assign o_res.power_on       = n_power;
    assign o_res.direction_down = (n_run_dir == arss_pkg::DIR_DOWN);
    assign o_res.brake_on       = n_brake;
    assign o_res.job_state      = w_job_code;
    assign o_res.stop_cause     = w_cause;
    assign o_res.pulse_total    = n_hall_total;

    // State registers, updated once per processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_dir    <= arss_pkg::DIR_STOP;
            r_run_speed  <= arss_pkg::RUN_SPEED_RESET;
            r_run_count  <= 1'b1;
            r_run_target <= arss_pkg::RUN_TARGET_RESET;
            r_hall_total <= '0;
            r_seen_total <= '0;
            r_stall      <= '0;
            r_job        <= JOB_FREE;
            r_drive      <= '0;
            r_power      <= 1'b0;
            r_brake      <= 1'b0;
        end else if (i_en) begin
            r_run_dir    <= n_run_dir;
            r_run_speed  <= n_run_speed;
            r_run_count  <= n_run_count;
            r_run_target <= n_run_target;
            r_hall_total <= n_hall_total;
            r_seen_total <= n_seen_total;
            r_stall      <= n_stall;
            r_job        <= n_job;
            r_drive      <= n_drive;
            r_power      <= n_power;
            r_brake      <= n_brake;
        end
    end

endmodule

// ----- src/actuator_run_with_stall_stop_unit.sv -----
// Top level of the actuator run unit: stream ports, input and result registers,
// configuration registers. Depends on arss_pkg and arss_ctrl.
//
// Takes one request transfer per clock when not stalled and returns exactly one
// result transfer per request, in order. A request passes through the input
// register and then the result register; the job controller between them
// updates all job state in the same cycle as the result register loads. Both
// sides may stall freely; a new request is taken whenever the input register
// is empty or moves on. Registers: stall timeout in ms at byte address 0,
// limit-switch stop enable at byte address 4; write them only while idle.
module actuator_run_with_stall_stop_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] job_dir, [8:2] job_speed, [9] job_count_mode, [25:10] job_target,
    // [29:26] hall_pulses, [30] limit_switch, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] drive_speed, [7] power_on, [8] direction_down, [9] brake_on,
    // [11:10] job_state, [13:12] stop_cause, [29:14] pulse_total, [31:30] zero
    output logic [31:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    arss_pkg::t_cfg    r_cfg;
    arss_pkg::t_req    r_in;
    logic              r_in_valid;
    arss_pkg::t_result r_out;
    logic              r_out_valid;
    arss_pkg::t_result w_res;
    logic              w_adv;
    logic              w_cfg_wr;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_timeout_ms   <= arss_pkg::STALL_TIMEOUT_RESET;
            r_cfg.switch_stop_enable <= 1'b1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == arss_pkg::REG_STALL_TIMEOUT) begin
                r_cfg.stall_timeout_ms <= pwdata[15:0];
            end else begin
                r_cfg.switch_stop_enable <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == arss_pkg::REG_SWITCH_STOP) ?
                    {31'b0, r_cfg.switch_stop_enable} :
                    {16'b0, r_cfg.stall_timeout_ms};

    // Input register
    assign w_adv         = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.req_type       <= s_axis_tuser;
            r_in.job_dir        <= s_axis_tdata[1:0];
            r_in.job_speed      <= s_axis_tdata[8:2];
            r_in.job_count_mode <= s_axis_tdata[9];
            r_in.job_target     <= s_axis_tdata[25:10];
            r_in.hall_pulses    <= s_axis_tdata[29:26];
            r_in.limit_switch   <= s_axis_tdata[30];
        end
    end

    // Job controller
    arss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b0, r_out.pulse_total, r_out.stop_cause, r_out.job_state,
                            r_out.brake_on, r_out.direction_down, r_out.power_on,
                            r_out.drive_speed};

endmodule

// ----- src/arss_chk.sv -----
// Port checker for the actuator run unit, bound to the top level.
// Depends on arss_pkg and the top level's result port names.
module arss_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Any stop leaves the job complete with power and drive off
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[13:12] != arss_pkg::CAUSE_NONE) |->
        (m_axis_tdata[11:10] == arss_pkg::STATUS_DONE) && !m_axis_tdata[7] &&
        (m_axis_tdata[6:0] == 7'd0))
        else $error("stop without job complete and drive off");

    // Power and brake never both on
    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> !m_axis_tdata[9])
        else $error("brake applied while powered");

    // Drive speed is zero when unpowered and never above full duty
    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= arss_pkg::SPEED_MAX) &&
        (m_axis_tdata[7] || (m_axis_tdata[6:0] == 7'd0)))
        else $error("drive speed out of range");

endmodule

bind actuator_run_with_stall_stop_unit arss_chk u_arss_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/actuator_run_checker.sv -----
// Checker for the actuator run unit: watches the request, result and config ports.
// Predicts each result from its own copy of the job state and compares in order.
// Depends on arss_pkg.
module actuator_run_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,
    input  logic [1:0]  i_req_kind,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Register copies
    logic [15:0] stall_timeout_ms;
    logic        switch_stop_en;

    // Job state copy
    logic [1:0]  run_dir;
    logic [6:0]  run_speed;
    logic        run_count_mode;
    logic [15:0] run_target;
    logic [15:0] hall_total;
    logic [15:0] seen_total;
    logic [19:0] stall_ticks;
    logic [1:0]  job_status;
    logic [6:0]  held_drive;
    logic        held_power;
    logic        held_brake;

    arss_pkg::t_result expected_results [$];
    arss_pkg::t_req    req;
    arss_pkg::t_result want;
    arss_pkg::t_result got;
    int      fail_total = 0;
    int      checked_total = 0;

    // Job end: motion off, counts cleared, status complete
    function automatic void finish_job();
        run_dir    = arss_pkg::DIR_STOP;
        hall_total = '0;
        seen_total = '0;
        stall_ticks = '0;
        job_status = arss_pkg::STATUS_DONE;
        held_drive = '0;
        held_power = 1'b0;
    endfunction

    // One request in, one result out
    function automatic arss_pkg::t_result actuator_step(input arss_pkg::t_req r);
        arss_pkg::t_result res;
        logic [1:0]  cause;
        logic        stall;
        logic [16:0] hall_sum;
        logic [19:0] stall_limit;
        cause = arss_pkg::CAUSE_NONE;
        stall = 1'b0;
        stall_limit = stall_timeout_ms * arss_pkg::TICKS_PER_MS;
        case (r.req_type)
            arss_pkg::REQ_TICK: begin
                if (run_dir == arss_pkg::DIR_STOP) begin
                    held_brake  = switch_stop_en;
                    held_drive  = '0;
                    held_power  = 1'b0;
                    hall_total  = '0;
                    seen_total  = '0;
                    stall_ticks = '0;
                end else begin
                    held_brake = 1'b0;
                    held_power = 1'b1;
                    hall_sum = {1'b0, hall_total} + {13'b0, r.hall_pulses};
                    hall_total = hall_sum[16] ? arss_pkg::COUNT_MAX : hall_sum[15:0];
                    if (hall_total != seen_total) begin
                        seen_total  = hall_total;
                        stall_ticks = '0;
                    end else begin
                        if (stall_ticks < arss_pkg::STALL_MAX)
                            stall_ticks = stall_ticks + 20'd1;
                        if (stall_ticks >= stall_limit)
                            stall = 1'b1;
                    end
                    // stall wins over target, target over limit switch
                    if (stall)
                        cause = arss_pkg::CAUSE_STALL;
                    else if (run_count_mode && hall_total >= run_target)
                        cause = arss_pkg::CAUSE_TARGET;
                    if (cause != arss_pkg::CAUSE_NONE) begin
                        finish_job();
                    end else if (switch_stop_en && r.limit_switch &&
                                 run_dir == arss_pkg::DIR_DOWN) begin
                        cause = arss_pkg::CAUSE_LIMIT;
                        finish_job();
                        held_brake = 1'b1;
                    end else if (run_speed <= arss_pkg::SPEED_MAX) begin
                        held_drive = run_speed;
                    end
                end
            end
            arss_pkg::REQ_START: begin
                if (job_status == arss_pkg::STATUS_FREE) begin
                    run_dir        = r.job_dir;
                    run_speed      = r.job_speed;
                    run_count_mode = r.job_count_mode;
                    run_target     = r.job_target;
                    hall_total     = '0;
                    seen_total     = '0;
                    stall_ticks    = '0;
                    job_status     = arss_pkg::STATUS_RUN;
                end
            end
            arss_pkg::REQ_CLEAR: begin
                job_status = arss_pkg::STATUS_FREE;
            end
            default: ;
        endcase
        res.drive_speed    = held_drive;
        res.power_on       = held_power;
        res.direction_down = (run_dir == arss_pkg::DIR_DOWN);
        res.brake_on       = held_brake;
        res.job_state      = job_status;
        res.stop_cause     = cause;
        res.pulse_total    = hall_total;
        return res;
    endfunction

    // Sample all ports at the clock edge, results before requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_timeout_ms = arss_pkg::STALL_TIMEOUT_RESET;
            switch_stop_en   = 1'b1;
            run_dir          = arss_pkg::DIR_STOP;
            run_speed        = arss_pkg::RUN_SPEED_RESET;
            run_count_mode   = 1'b1;
            run_target       = arss_pkg::RUN_TARGET_RESET;
            hall_total       = '0;
            seen_total       = '0;
            stall_ticks      = '0;
            job_status       = arss_pkg::STATUS_FREE;
            held_drive       = '0;
            held_power       = 1'b0;
            held_brake       = 1'b0;
            expected_results.delete();
        end else begin
            // config write snoop
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == arss_pkg::REG_STALL_TIMEOUT)
                    stall_timeout_ms = i_pwdata[15:0];
                else
                    switch_stop_en = i_pwdata[0];
            end
            // result transfer
            if (i_res_valid && i_res_ready) begin
                got.drive_speed    = i_res_data[6:0];
                got.power_on       = i_res_data[7];
                got.direction_down = i_res_data[8];
                got.brake_on       = i_res_data[9];
                got.job_state      = i_res_data[11:10];
                got.stop_cause     = i_res_data[13:12];
                got.pulse_total    = i_res_data[29:14];
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("Unexpected result transfer: data %h", i_res_data);
                end else begin
                    want = expected_results.pop_front();
                    checked_total++;
                    if (got.drive_speed !== want.drive_speed ||
                        got.power_on !== want.power_on ||
                        got.direction_down !== want.direction_down ||
                        got.brake_on !== want.brake_on ||
                        got.job_state !== want.job_state ||
                        got.stop_cause !== want.stop_cause ||
                        got.pulse_total !== want.pulse_total) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("Result %0d differs:", checked_total);
                            $display("  exp speed %0d pwr %0b down %0b brake %0b state %0d cause %0d total %0d",
                                     want.drive_speed, want.power_on, want.direction_down,
                                     want.brake_on, want.job_state, want.stop_cause,
                                     want.pulse_total);
                            $display("  got speed %0d pwr %0b down %0b brake %0b state %0d cause %0d total %0d",
                                     got.drive_speed, got.power_on, got.direction_down,
                                     got.brake_on, got.job_state, got.stop_cause,
                                     got.pulse_total);
                        end
                    end
                end
            end
            // request transfer
            if (i_req_valid && i_req_ready) begin
                req.req_type       = i_req_kind;
                req.job_dir        = i_req_data[1:0];
                req.job_speed      = i_req_data[8:2];
                req.job_count_mode = i_req_data[9];
                req.job_target     = i_req_data[25:10];
                req.hall_pulses    = i_req_data[29:26];
                req.limit_switch   = i_req_data[30];
                expected_results.push_back(actuator_step(req));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

// ----- dv/actuator_run_with_stall_stop_unit_tb.sv -----
// Testbench top for the actuator run unit: clock, reset, stimulus and verdict.
// Directed jobs and random job sequences over several register settings.
// Depends on arss_pkg, actuator_run_checker and the unit.
module actuator_run_with_stall_stop_unit_tb;

    localparam int          CYCLE_LIMIT     = 600000;
    localparam int          ITEMS_PER_PHASE = 216;
    localparam int          NUM_PHASES      = 8;
    localparam int          SETTLE_CYCLES   = 10;
    localparam logic [1:0]  DIR_OTHER       = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;
    int results_checked;
    int cycle_count = 0;
    int sent_count = 0;
    int burst_left = 0;
    int ready_tick = 0;
    int ready_mode = 0;
    int settings_used = 0;

    logic [15:0] phase_timeouts [0:NUM_PHASES-1] =
        '{16'd0, 16'd1, 16'd2, 16'd3, 16'd1, 16'd5, 16'd0, 16'd65535};
    logic        phase_switch_en [0:NUM_PHASES-1] =
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    actuator_run_with_stall_stop_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    actuator_run_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_kind   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (results_checked)
    );

    // Result side backpressure: one of four ready patterns, chosen at random
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 48 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 2) == 0);
            default: m_axis_tready <= ready_tick[2];
        endcase
    end

    // Request of the given kind; fields the kind ignores carry random noise
    function automatic arss_pkg::t_req request_of(input logic [1:0] kind);
        arss_pkg::t_req r;
        r.req_type       = kind;
        r.job_dir        = 2'($urandom_range(0, 3));
        r.job_speed      = 7'($urandom_range(0, 127));
        r.job_count_mode = 1'($urandom_range(0, 1));
        r.job_target     = 16'($urandom_range(0, 65535));
        r.hall_pulses    = 4'($urandom_range(0, 15));
        r.limit_switch   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic arss_pkg::t_req tick_req(input logic [3:0] pulses, input logic sw);
        arss_pkg::t_req r;
        r = request_of(arss_pkg::REQ_TICK);
        r.hall_pulses  = pulses;
        r.limit_switch = sw;
        return r;
    endfunction

    function automatic arss_pkg::t_req start_req(input logic [1:0] dir,
                                                 input logic [6:0] speed,
                                                 input logic mode,
                                                 input logic [15:0] target);
        arss_pkg::t_req r;
        r = request_of(arss_pkg::REQ_START);
        r.job_dir        = dir;
        r.job_speed      = speed;
        r.job_count_mode = mode;
        r.job_target     = target;
        return r;
    endfunction

    // One request transfer; bursts with random gaps between them
    task automatic send_item(input arss_pkg::t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req_type;
        s_axis_tdata  <= {1'b0, r.limit_switch, r.hall_pulses, r.job_target,
                          r.job_count_mode, r.job_speed, r.job_dir};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // Setup cycle then access cycle
    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Usually a clear, then a start and a run of ticks; a few requests in between are noise
    task automatic run_job();
        arss_pkg::t_req r;
        int   n_ticks;
        bit   stall_style;
        if ($urandom_range(0, 7) != 0)
            send_item(request_of(arss_pkg::REQ_CLEAR));
        r = request_of(arss_pkg::REQ_START);
        case ($urandom_range(0, 9))
            0: r.job_dir = arss_pkg::DIR_STOP;
            1: r.job_dir = DIR_OTHER;
            2, 3, 4, 5: r.job_dir = arss_pkg::DIR_UP;
            default: r.job_dir = arss_pkg::DIR_DOWN;
        endcase
        r.job_speed = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(101, 127))
                                                  : 7'($urandom_range(0, 100));
        r.job_target = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 80));
        send_item(r);
        n_ticks = $urandom_range(1, 50);
        stall_style = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                r = request_of(2'($urandom_range(1, 3)));
            end else begin
                r = request_of(arss_pkg::REQ_TICK);
                if ((stall_style && i > 2) || $urandom_range(0, 3) == 0)
                    r.hall_pulses = '0;
                r.limit_switch = ($urandom_range(0, 9) == 0);
            end
            send_item(r);
        end
    endtask

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout at cycle %0d with %0d results outstanding",
                 cycle_count, pending_results);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed jobs under reset register values
        send_item(tick_req(4'd15, 1'b1));              // stopped: brake from enable
        send_item(request_of(arss_pkg::REQ_CLEAR));
        send_item(request_of(arss_pkg::REQ_NOP));
        send_item(start_req(arss_pkg::DIR_UP, 7'd127, 1'b1, 16'd5));
        send_item(tick_req(4'd3, 1'b1));               // speed above limit held off
        send_item(tick_req(4'd2, 1'b0));               // target reached
        send_item(start_req(arss_pkg::DIR_DOWN, 7'd30, 1'b0, 16'd9)); // ignored, not free
        send_item(tick_req(4'd0, 1'b1));
        send_item(request_of(arss_pkg::REQ_CLEAR));
        send_item(start_req(arss_pkg::DIR_UP, 7'd0, 1'b1, 16'd0));
        send_item(tick_req(4'd0, 1'b0));               // zero target
        send_item(request_of(arss_pkg::REQ_CLEAR));
        send_item(start_req(arss_pkg::DIR_DOWN, 7'd100, 1'b0, 16'hFFFF));
        send_item(tick_req(4'd15, 1'b0));
        send_item(tick_req(4'd0, 1'b1));               // limit switch stop
        send_item(request_of(arss_pkg::REQ_CLEAR));
        send_item(start_req(arss_pkg::DIR_STOP, 7'd50, 1'b1, 16'd20)); // runs without motion
        send_item(tick_req(4'd4, 1'b1));
        send_item(request_of(arss_pkg::REQ_CLEAR));
        send_item(start_req(DIR_OTHER, 7'd42, 1'b1, 16'd20));
        send_item(request_of(arss_pkg::REQ_CLEAR));    // clear while moving
        send_item(tick_req(4'd15, 1'b1));
        send_item(start_req(arss_pkg::DIR_DOWN, 7'd60, 1'b0, 16'd9)); // reload while moving
        send_item(tick_req(4'd9, 1'b0));
        send_item(request_of(arss_pkg::REQ_CLEAR));

        // Random jobs over several register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_results_drained();
            reg_write(arss_pkg::REG_STALL_TIMEOUT, {16'd0, phase_timeouts[p]});
            reg_write(arss_pkg::REG_SWITCH_STOP, {31'd0, phase_switch_en[p]});
            settings_used++;
            for (int n = sent_count + ITEMS_PER_PHASE; sent_count < n; )
                run_job();
        end

        // Job without motion at the end
        send_item(request_of(arss_pkg::REQ_CLEAR));
        send_item(start_req(arss_pkg::DIR_STOP, 7'd10, 1'b1, 16'd1));
        send_item(tick_req(4'd1, 1'b0));

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d request transfers over %0d register settings,",
                 sent_count, settings_used + 1);
        $display("directed jobs and random job sequences; %0d results checked",
                 results_checked);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/arss_pkg.sv
src/arss_ctrl.sv
src/actuator_run_with_stall_stop_unit.sv
src/arss_chk.sv
dv/actuator_run_checker.sv
dv/actuator_run_with_stall_stop_unit_tb.sv
